// ----- hdl/cke_pkg.sv -----
package cke_pkg;

  // operand width and the fixed width of the result fields
  localparam int DATA_W = 32;
  localparam int OUT_W  = 32;
  localparam int CNT_W  = $clog2(DATA_W + 1);

  typedef logic [DATA_W-1:0]        word_t;
  typedef logic signed [DATA_W-1:0] sword_t;
  typedef logic signed [OUT_W-1:0]  out_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  // special key codes
  localparam logic [7:0] KEY_ZERO   = 8'h30;
  localparam logic [7:0] KEY_NINE   = 8'h39;
  localparam logic [7:0] KEY_NEG    = 8'h6d;
  localparam logic [7:0] KEY_PLUS   = 8'h2b;
  localparam logic [7:0] KEY_MINUS  = 8'h2d;
  localparam logic [7:0] KEY_TIMES  = 8'h2a;
  localparam logic [7:0] KEY_SLASH  = 8'h2f;
  localparam logic [7:0] KEY_RETURN = 8'h0d;
  localparam logic [7:0] KEY_CLEAR  = 8'h63;
  localparam logic [7:0] KEY_QUIT_L = 8'h71;
  localparam logic [7:0] KEY_QUIT_U = 8'h51;

  typedef enum logic [2:0] {
    PH_A_FRESH = 3'd0,
    PH_A_BUSY  = 3'd1,
    PH_B_FRESH = 3'd2,
    PH_B_BUSY  = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KC_DIGIT,
    KC_NEG,
    KC_OPER,
    KC_RET,
    KC_CLEAR,
    KC_QUIT,
    KC_OTHER
  } kclass_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_SETUP,
    S_RUN,
    S_LOAD
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic take_key;
    logic apply;
    logic start;
    logic step;
    logic load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    kclass_t key_class;
    logic    finished;
    logic    iterative;
    logic    step_last;
    logic    out_free;
  } sts_t;

  function automatic kclass_t classify(logic [7:0] key);
    kclass_t kc;
    if (key >= KEY_ZERO && key <= KEY_NINE) begin
      kc = KC_DIGIT;
    end else if (key == KEY_NEG) begin
      kc = KC_NEG;
    end else if (key == KEY_PLUS || key == KEY_MINUS || key == KEY_TIMES ||
                 key == KEY_SLASH) begin
      kc = KC_OPER;
    end else if (key == KEY_RETURN) begin
      kc = KC_RET;
    end else if (key == KEY_CLEAR) begin
      kc = KC_CLEAR;
    end else if (key == KEY_QUIT_L || key == KEY_QUIT_U) begin
      kc = KC_QUIT;
    end else begin
      kc = KC_OTHER;
    end
    return kc;
  endfunction

  function automatic op_t key_op(logic [7:0] key);
    op_t op;
    if (key == KEY_PLUS) begin
      op = OP_ADD;
    end else if (key == KEY_MINUS) begin
      op = OP_SUB;
    end else if (key == KEY_TIMES) begin
      op = OP_MUL;
    end else begin
      op = OP_DIV;
    end
    return op;
  endfunction

endpackage

// ----- hdl/cke_key_if.sv -----
interface cke_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_code;

  modport source(output valid, output key_code, input ready);
  modport sink(input valid, input key_code, output ready);
endinterface

// ----- hdl/cke_res_if.sv -----
interface cke_res_if;
  logic                 valid;
  logic                 ready;
  cke_pkg::out_t        result_value;
  cke_pkg::out_t        first_operand;
  cke_pkg::out_t        second_operand;
  logic [1:0]           operator_code;
  logic [2:0]           entry_phase;
  logic                 divisor_zero;

  modport source(output valid, output result_value, output first_operand,
                 output second_operand, output operator_code, output entry_phase,
                 output divisor_zero, input ready);
  modport sink(input valid, input result_value, input first_operand,
               input second_operand, input operator_code, input entry_phase,
               input divisor_zero, output ready);
endinterface

// ----- hdl/cke_ctrl.sv -----
module cke_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cke_pkg::sts_t sts,
  output cke_pkg::cmd_t cmd
);

  cke_pkg::state_t state_r;
  cke_pkg::state_t state_nxt;
  logic            drop;

  // key that produces no word: unknown key or session finished
  assign drop = sts.finished || (sts.key_class == cke_pkg::KC_OTHER);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cke_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cke_pkg::S_IDLE: begin
        if (in_valid) state_nxt = cke_pkg::S_UPDATE;
      end
      cke_pkg::S_UPDATE: begin
        state_nxt = drop ? cke_pkg::S_IDLE : cke_pkg::S_SETUP;
      end
      cke_pkg::S_SETUP: begin
        state_nxt = sts.iterative ? cke_pkg::S_RUN : cke_pkg::S_LOAD;
      end
      cke_pkg::S_RUN: begin
        if (sts.step_last) state_nxt = cke_pkg::S_LOAD;
      end
      cke_pkg::S_LOAD: begin
        if (sts.out_free) state_nxt = cke_pkg::S_IDLE;
      end
      default: state_nxt = cke_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state_r)
      cke_pkg::S_IDLE: begin
        in_ready     = 1'b1;
        cmd.take_key = in_valid;
      end
      cke_pkg::S_UPDATE: cmd.apply = !drop;
      cke_pkg::S_SETUP:  cmd.start = 1'b1;
      cke_pkg::S_RUN:    cmd.step  = 1'b1;
      cke_pkg::S_LOAD:   cmd.load  = sts.out_free;
      default: ;
    endcase
  end

  // a result is written only into a free output slot
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> sts.out_free)
    else $error("result loaded into a busy output slot");

  // the iterative unit is not left early
  a_run_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cke_pkg::S_RUN) && !sts.step_last |=> state_r == cke_pkg::S_RUN)
    else $error("iteration left before its last step");

  // a dropped key returns straight to idle
  a_drop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cke_pkg::S_UPDATE) && drop |=> state_r == cke_pkg::S_IDLE)
    else $error("ignored key did not return to idle");

endmodule

// ----- hdl/cke_dp.sv -----
module cke_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       key_code,
  input  cke_pkg::cmd_t    cmd,
  output cke_pkg::sts_t    sts,
  cke_res_if.source        out_ch
);

  logic [7:0]           key_r;
  cke_pkg::phase_t      phase_r, phase_nxt;
  cke_pkg::word_t       a_r, a_nxt;
  cke_pkg::word_t       b_r, b_nxt;
  cke_pkg::op_t         op_r, op_nxt;
  cke_pkg::word_t       acc_r;
  cke_pkg::word_t       x_r;
  cke_pkg::word_t       y_r;
  cke_pkg::cnt_t        cnt_r;
  logic                 neg_r;
  logic                 out_valid_r;
  cke_pkg::out_t        res_r, a_out_r, b_out_r;
  cke_pkg::op_t         op_out_r;
  cke_pkg::phase_t      phase_out_r;
  logic                 dz_out_r;

  cke_pkg::kclass_t     kclass;
  cke_pkg::word_t       digit;
  cke_pkg::word_t       abs_a, abs_b;
  logic                 on_b;
  logic                 iterative;
  logic [cke_pkg::DATA_W+1:0] trial;
  cke_pkg::word_t       result;

  assign kclass    = cke_pkg::classify(key_r);
  assign digit     = cke_pkg::word_t'(key_r[3:0]);
  assign on_b      = (phase_r == cke_pkg::PH_B_FRESH) || (phase_r == cke_pkg::PH_B_BUSY);
  assign iterative = (op_r == cke_pkg::OP_MUL) || (op_r == cke_pkg::OP_DIV);

  // status toward the controller
  always_comb begin
    sts.key_class = kclass;
    sts.finished  = (phase_r == cke_pkg::PH_DONE);
    sts.iterative = iterative;
    sts.step_last = (cnt_r == cke_pkg::cnt_t'(1));
    sts.out_free  = !out_valid_r || out_ch.ready;
  end

  // key register
  always_ff @(posedge clk) begin
    if (cmd.take_key) key_r <= key_code;
  end

  // entry state update for one recognized key
  always_comb begin
    phase_nxt = phase_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    op_nxt    = op_r;
    unique case (kclass)
      cke_pkg::KC_DIGIT: begin
        unique case (phase_r)
          cke_pkg::PH_A_FRESH: begin
            a_nxt     = digit;
            phase_nxt = cke_pkg::PH_A_BUSY;
          end
          cke_pkg::PH_A_BUSY: a_nxt = (a_r << 3) + (a_r << 1) + digit;
          cke_pkg::PH_B_FRESH: begin
            b_nxt     = digit;
            phase_nxt = cke_pkg::PH_B_BUSY;
          end
          default: b_nxt = (b_r << 3) + (b_r << 1) + digit;
        endcase
      end
      cke_pkg::KC_NEG: begin
        if (on_b) begin
          b_nxt = cke_pkg::word_t'(0) - b_r;
        end else begin
          a_nxt = cke_pkg::word_t'(0) - a_r;
        end
      end
      cke_pkg::KC_OPER: begin
        op_nxt = cke_pkg::key_op(key_r);
        if (phase_r != cke_pkg::PH_B_BUSY) phase_nxt = cke_pkg::PH_B_FRESH;
      end
      cke_pkg::KC_RET: begin
        phase_nxt = on_b ? cke_pkg::PH_A_FRESH : cke_pkg::PH_B_FRESH;
      end
      cke_pkg::KC_CLEAR: begin
        a_nxt     = '0;
        b_nxt     = '0;
        op_nxt    = cke_pkg::OP_ADD;
        phase_nxt = cke_pkg::PH_A_FRESH;
      end
      cke_pkg::KC_QUIT: phase_nxt = cke_pkg::PH_DONE;
      default: ;
    endcase
  end

  // entry state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cke_pkg::PH_A_FRESH;
      a_r     <= '0;
      b_r     <= '0;
      op_r    <= cke_pkg::OP_ADD;
    end else if (cmd.apply) begin
      phase_r <= phase_nxt;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      op_r    <= op_nxt;
    end
  end

  // magnitudes for the divider, zero divisor becomes one
  assign abs_a = a_r[cke_pkg::DATA_W-1] ? cke_pkg::word_t'(0) - a_r : a_r;
  assign abs_b = (b_r == '0) ? cke_pkg::word_t'(1)
               : (b_r[cke_pkg::DATA_W-1] ? cke_pkg::word_t'(0) - b_r : b_r);

  // restoring divide trial subtraction
  assign trial = {1'b0, acc_r, x_r[cke_pkg::DATA_W-1]} - {2'b00, y_r};

  // shift-add multiplier and restoring divider, one bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.start) begin
      acc_r <= '0;
      cnt_r <= cke_pkg::cnt_t'(cke_pkg::DATA_W);
      neg_r <= a_r[cke_pkg::DATA_W-1] ^ b_r[cke_pkg::DATA_W-1];
      if (op_r == cke_pkg::OP_MUL) begin
        x_r <= a_r;
        y_r <= b_r;
      end else begin
        x_r <= abs_a;
        y_r <= abs_b;
      end
    end else if (cmd.step) begin
      cnt_r <= cnt_r - cke_pkg::cnt_t'(1);
      if (op_r == cke_pkg::OP_MUL) begin
        if (y_r[0]) acc_r <= acc_r + x_r;
        x_r <= x_r << 1;
        y_r <= y_r >> 1;
      end else if (!trial[cke_pkg::DATA_W+1]) begin
        acc_r <= trial[cke_pkg::DATA_W-1:0];
        x_r   <= {x_r[cke_pkg::DATA_W-2:0], 1'b1};
      end else begin
        acc_r <= {acc_r[cke_pkg::DATA_W-2:0], x_r[cke_pkg::DATA_W-1]};
        x_r   <= {x_r[cke_pkg::DATA_W-2:0], 1'b0};
      end
    end
  end

  // final result select
  always_comb begin
    case (op_r)
      cke_pkg::OP_ADD: result = a_r + b_r;
      cke_pkg::OP_SUB: result = a_r - b_r;
      cke_pkg::OP_MUL: result = acc_r;
      default:         result = neg_r ? cke_pkg::word_t'(0) - x_r : x_r;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_r       <= cke_pkg::out_t'(cke_pkg::sword_t'(result));
      a_out_r     <= cke_pkg::out_t'(cke_pkg::sword_t'(a_r));
      b_out_r     <= cke_pkg::out_t'(cke_pkg::sword_t'(b_r));
      op_out_r    <= op_r;
      phase_out_r <= phase_r;
      dz_out_r    <= (op_r == cke_pkg::OP_DIV) && (b_r == '0);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_value   = res_r;
  assign out_ch.first_operand  = a_out_r;
  assign out_ch.second_operand = b_out_r;
  assign out_ch.operator_code  = op_out_r;
  assign out_ch.entry_phase    = phase_out_r;
  assign out_ch.divisor_zero   = dz_out_r;

  // a loaded word is presented next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid_r)
    else $error("loaded word not presented");

  // the iteration counter never underflows
  a_step_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> cnt_r != '0)
    else $error("step issued with iteration count exhausted");

  // the finished phase holds until reset
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == cke_pkg::PH_DONE |=> phase_r == cke_pkg::PH_DONE)
    else $error("finished session resumed without reset");

endmodule

// ----- hdl/calculator_key_entry_fsm_unit.sv -----
// Calculator key entry unit.
// in_key carries one ASCII key code per word (valid/ready). Digits build the
// active operand, 'm' negates it, + - * / pick the operation, return (13)
// switches to the other operand, 'c' clears and 'q'/'Q' ends the session. Each recognized
// key yields one word on out_res: the operation applied to both operands
// (wrapping, truncating divide, zero divisor taken as one), both operands,
// the operation code, the entry phase and a zero-divisor flag. Other keys,
// and every key after quit, are taken and yield nothing.
// Add and subtract go from the accepted key through the update and setup
// states to the output register; multiply and divide also pass through the
// shared shift-add/restoring unit, which retires one bit per cycle over 32 bits.
// A new key is taken once the previous one has reached the output register;
// an unknown key returns to idle straight after the update state.
// While out_res is stalled the finished word waits in the output register
// and one further recognized key is accepted and processed, then held until it frees.
// Synchronous active-low reset clears operands, operation (add), phase and
// the output valid.
module calculator_key_entry_fsm_unit (
  input  logic      clk,
  input  logic      rst_n,
  cke_key_if.sink   in_key,
  cke_res_if.source out_res
);

  cke_pkg::cmd_t cmd;
  cke_pkg::sts_t sts;
  logic          in_ready;

  assign in_key.ready = in_ready;

  // sequencer
  cke_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_key.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // operands, arithmetic unit and output register
  cke_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .key_code (in_key.key_code),
    .cmd      (cmd),
    .sts      (sts),
    .out_ch   (out_res)
  );

endmodule
